// ----- src/quad_cell_area_pressure_unit_defines.svh -----
// Assertion macros used by the top RTL file of the cell area and pressure unit.
`ifndef QUAD_CELL_AREA_PRESSURE_UNIT_DEFINES_SVH
`define QUAD_CELL_AREA_PRESSURE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define QCAP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define QCAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/qcap_pkg.sv -----
package qcap_pkg;

   // fixed field widths
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int GAMMA_W       = 18;
   localparam int GAMMA_FRAC    = 16;
   localparam int OUT_W         = 48;
   localparam int GE_W          = 51;   // (gamma - 1) * energy, signed
   localparam int REQ_W         = 10 * COORD_W;
   localparam int RSP_W         = 3 * OUT_W;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;  // 1.4 in Q2.16

   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // per-cell side data carried along the pipeline
   typedef struct packed {
      logic                    bad;
      logic signed [OUT_W-1:0] area;
      logic signed [GE_W-1:0]  ge;
   } cell_meta_type;

   // one result beat
   typedef struct packed {
      logic                    bad_cell;
      logic signed [OUT_W-1:0] cell_pressure;
      logic signed [OUT_W-1:0] cell_density;
      logic signed [OUT_W-1:0] cell_area;
   } rsp_beat_type;

endpackage

// ----- src/quad_cell_area_pressure_unit.sv -----
// Quadrilateral cell area, density and ideal-gas pressure.
// req_ channel: one beat per cell, four vertices in order plus mass and
//   specific energy, all fixed point with FRAC_BITS fraction bits.
// rsp_ channel: one beat per cell, in order: signed area, density and
//   pressure (Q32.16 at default), and bad_cell in rsp_tuser. A cell that is
//   not strictly convex, or whose area rounds to zero, gives zeros and flag.
// csr_ channel: writes gamma (Q2.16); always ready. Write only while idle.
// Throughput: one cell per clock while the output queue has room. Stages:
//   five geometry stages, a restoring divider with one quotient bit per
//   stage (FRAC_BITS + 33 stages) plus setup and sign stages, four pressure
//   multiply stages and the output queue.
// Stalls: results land in a two-beat output queue; the pipeline freezes as a
//   whole only when that queue is full, so one result can wait while new
//   cells are still taken. Nothing is lost or repeated on a stall.
// Reset: synchronous, clears all valid bits and the queue, and sets gamma
//   to 1.4.
`include "quad_cell_area_pressure_unit_defines.svh"

module quad_cell_area_pressure_unit #(
   parameter int FRAC_BITS = qcap_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
   // cell_mass, specific_energy (32 bits each)
   input  logic [qcap_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_area, cell_density, cell_pressure (48 bits each)
   output logic [qcap_pkg::RSP_W-1:0]        rsp_tdata,
   // bad_cell
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qcap_pkg::GAMMA_W-1:0]      csr_data
);
   import qcap_pkg::*;

   logic [GAMMA_W-1:0]        gamma_ff;
   logic                      en;
   logic signed [COORD_W-1:0] vert_x [4];
   logic signed [COORD_W-1:0] vert_y [4];

   logic                      g_valid;
   cell_meta_type             g_meta;
   logic [COORD_W-1:0]        g_mass;
   logic                      d_valid;
   cell_meta_type             d_meta;
   logic signed [OUT_W-1:0]   d_dens;
   logic                      p_valid;
   rsp_beat_type              p_beat;

   rsp_beat_type              q_ff [2];
   logic                      wr_ptr_ff;
   logic                      rd_ptr_ff;
   logic [1:0]                cnt_ff;
   logic [1:0]                cnt_in;
   logic                      push;
   logic                      pop;

   // gamma register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
      end else if (csr_valid && csr_ready) begin
         gamma_ff <= csr_data;
      end
   end

   // unpack request beat
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         vert_x[k] = req_tdata[2*k*COORD_W +: COORD_W];
         vert_y[k] = req_tdata[(2*k+1)*COORD_W +: COORD_W];
      end
   end

   // pipeline moves while the output queue has room
   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   qcap_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_tvalid),
      .vert_x          (vert_x),
      .vert_y          (vert_y),
      .cell_mass       (req_tdata[8*COORD_W +: COORD_W]),
      .specific_energy (req_tdata[9*COORD_W +: COORD_W]),
      .gamma_ratio     (gamma_ff),
      .out_valid       (g_valid),
      .out_meta        (g_meta),
      .out_mass        (g_mass)
   );

   qcap_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_meta   (g_meta),
      .in_mass   (g_mass),
      .out_valid (d_valid),
      .out_meta  (d_meta),
      .out_dens  (d_dens)
   );

   qcap_press #(.FRAC_BITS(FRAC_BITS)) u_press (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_meta   (d_meta),
      .in_dens   (d_dens),
      .out_valid (p_valid),
      .out_beat  (p_beat)
   );

   // two-beat output queue
   assign push   = en && p_valid;
   assign pop    = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= p_beat;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[rd_ptr_ff].cell_pressure, q_ff[rd_ptr_ff].cell_density,
                        q_ff[rd_ptr_ff].cell_area};
   assign rsp_tuser  = q_ff[rd_ptr_ff].bad_cell;

   `QCAP_ASSERT_NOW(a_bad_gives_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "flagged cell carries nonzero results")
   `QCAP_ASSERT_NOW(a_dens_sign, rsp_tvalid && !rsp_tuser && !rsp_tdata[OUT_W-1], !rsp_tdata[2*OUT_W-1], "positive area with negative density")
   `QCAP_ASSERT_NEXT(a_gamma_write, csr_valid && csr_ready, gamma_ff == $past(csr_data), "gamma write lost")
   `QCAP_ASSERT_NEXT(a_queue_fill, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1, "queue count out of step")

endmodule

// ----- src/qcap_geom.sv -----
module qcap_geom #(
   parameter int FRAC_BITS = qcap_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic signed [qcap_pkg::COORD_W-1:0]      vert_x [4],
   input  logic signed [qcap_pkg::COORD_W-1:0]      vert_y [4],
   input  logic        [qcap_pkg::COORD_W-1:0]      cell_mass,
   input  logic        [qcap_pkg::COORD_W-1:0]      specific_energy,
   input  logic        [qcap_pkg::GAMMA_W-1:0]      gamma_ratio,
   output logic                                     out_valid,
   output qcap_pkg::cell_meta_type                  out_meta,
   output logic        [qcap_pkg::COORD_W-1:0]      out_mass
);
   import qcap_pkg::*;

   localparam int D_W     = COORD_W + 1;
   localparam int PROD_W  = 2 * D_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SL_W    = 2 * COORD_W;
   localparam int TERM_W  = SL_W + 1;
   localparam int TWICE_W = TERM_W + 3;
   localparam int GE_FULL = GAMMA_W + 1 + COORD_W + 1;

   // stage valid bits, mass and ge travel stages 1..5
   logic                    v_ff    [1:5];
   logic [COORD_W-1:0]      mass_ff [1:5];
   logic signed [GE_W-1:0]  ge_ff   [1:5];

   // stage 1: coordinates, edge differences, (gamma - 1) * energy
   logic signed [COORD_W-1:0] x1_ff [4];
   logic signed [COORD_W-1:0] y1_ff [4];
   logic signed [D_W-1:0]     a1_ff [4];
   logic signed [D_W-1:0]     b1_ff [4];
   logic signed [D_W-1:0]     c1_ff [4];
   logic signed [D_W-1:0]     d1_ff [4];
   logic signed [GAMMA_W:0]   gm1_in;
   logic signed [GE_FULL-1:0] ge1_in;

   // stage 2: products
   logic signed [PROD_W-1:0]  pa2_ff [4];
   logic signed [PROD_W-1:0]  pb2_ff [4];
   logic signed [SL_W-1:0]    sa2_ff [4];
   logic signed [SL_W-1:0]    sb2_ff [4];

   // stage 3: corner signs and shoelace terms
   logic [3:0]                neg3_ff;
   logic [3:0]                pos3_ff;
   logic signed [TERM_W-1:0]  tw3_ff [4];

   // stage 4: convexity and twice the area, rounded
   logic                      convex4_ff;
   logic signed [TWICE_W-1:0] twice4_ff;

   // stage 5: area and flag
   logic signed [OUT_W-1:0]   area5_ff;
   logic                      bad5_ff;
   logic signed [TWICE_W-1:0] sh5_in;
   logic [TWICE_W-OUT_W:0]    hi5_in;
   logic signed [OUT_W-1:0]   area5_in;

   assign gm1_in = $signed({1'b0, gamma_ratio}) - $signed((GAMMA_W+1)'(1 << GAMMA_FRAC));
   assign ge1_in = gm1_in * $signed({1'b0, specific_energy});

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 5; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[1] <= in_valid;
         for (int s = 2; s <= 5; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // side data chain
   always_ff @(posedge clock) begin
      if (en) begin
         mass_ff[1] <= cell_mass;
         ge_ff[1]   <= GE_W'(ge1_in);
         for (int s = 2; s <= 5; s++) begin
            mass_ff[s] <= mass_ff[s-1];
            ge_ff[s]   <= ge_ff[s-1];
         end
      end
   end

   // per-corner datapath, stages 1 to 3
   for (genvar k = 0; k < 4; k++) begin : g_corner
      localparam int K1 = (k + 1) % 4;
      localparam int K2 = (k + 2) % 4;
      logic signed [CROSS_W-1:0] cr_in;

      assign cr_in = CROSS_W'(pa2_ff[k]) - CROSS_W'(pb2_ff[k]);

      always_ff @(posedge clock) begin
         if (en) begin
            x1_ff[k]  <= vert_x[k];
            y1_ff[k]  <= vert_y[k];
            a1_ff[k]  <= D_W'(vert_x[K1]) - D_W'(vert_x[k]);
            b1_ff[k]  <= D_W'(vert_y[K2]) - D_W'(vert_y[k]);
            c1_ff[k]  <= D_W'(vert_y[K1]) - D_W'(vert_y[k]);
            d1_ff[k]  <= D_W'(vert_x[K2]) - D_W'(vert_x[k]);
            pa2_ff[k] <= a1_ff[k] * b1_ff[k];
            pb2_ff[k] <= c1_ff[k] * d1_ff[k];
            sa2_ff[k] <= x1_ff[k] * y1_ff[K1];
            sb2_ff[k] <= y1_ff[k] * x1_ff[K1];
            neg3_ff[k] <= cr_in[CROSS_W-1];
            pos3_ff[k] <= !cr_in[CROSS_W-1] && (|cr_in);
            tw3_ff[k]  <= TERM_W'(sa2_ff[k]) - TERM_W'(sb2_ff[k]);
         end
      end
   end

   // stage 5 shift and saturate
   always_comb begin
      sh5_in = twice4_ff >>> (FRAC_BITS + 1);
      hi5_in = sh5_in[TWICE_W-1:OUT_W-1];
      if ((&hi5_in) || !(|hi5_in)) begin
         area5_in = sh5_in[OUT_W-1:0];
      end else if (sh5_in[TWICE_W-1]) begin
         area5_in = OUT_MIN;
      end else begin
         area5_in = OUT_MAX;
      end
   end

   // stages 4 and 5
   always_ff @(posedge clock) begin
      if (en) begin
         convex4_ff <= (&pos3_ff) || (&neg3_ff);
         twice4_ff  <= TWICE_W'(tw3_ff[0]) + TWICE_W'(tw3_ff[1]) + TWICE_W'(tw3_ff[2])
                     + TWICE_W'(tw3_ff[3]) + (TWICE_W'(1) <<< FRAC_BITS);
         area5_ff   <= area5_in;
         bad5_ff    <= !convex4_ff || (area5_in == '0);
      end
   end

   assign out_valid = v_ff[5];
   assign out_mass  = mass_ff[5];
   assign out_meta  = '{bad: bad5_ff, area: area5_ff, ge: ge_ff[5]};

endmodule

// ----- src/qcap_div.sv -----
module qcap_div #(
   parameter int FRAC_BITS = qcap_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  qcap_pkg::cell_meta_type               in_meta,
   input  logic [qcap_pkg::COORD_W-1:0]          in_mass,
   output logic                                  out_valid,
   output qcap_pkg::cell_meta_type               out_meta,
   output logic signed [qcap_pkg::OUT_W-1:0]     out_dens
);
   import qcap_pkg::*;

   localparam int NUM_W = COORD_W + FRAC_BITS + 1;
   localparam int MAG_W = OUT_W;
   localparam int QX_W  = (NUM_W > OUT_W + 1) ? NUM_W : OUT_W + 1;

   // stage 0 is the setup, stage i+1 holds i+1 quotient bits
   logic                 v_ff    [NUM_W+1];
   cell_meta_type        meta_ff [NUM_W+1];
   logic [MAG_W-1:0]     rem_ff  [NUM_W+1];
   logic [MAG_W-1:0]     d_ff    [NUM_W+1];
   logic [NUM_W-1:0]     nq_ff   [NUM_W+1];

   logic [MAG_W-1:0]     mag_in;
   logic [NUM_W-1:0]     num_in;
   logic [QX_W-1:0]      qx_in;
   logic signed [OUT_W-1:0] dens_in;

   logic                 vo_ff;
   cell_meta_type        meta_o_ff;
   logic signed [OUT_W-1:0] dens_ff;

   // |area| and mass scaled, plus half the divisor for rounding
   always_comb begin
      mag_in = in_meta.area[OUT_W-1] ? (~in_meta.area + 1'b1) : in_meta.area;
      num_in = NUM_W'({in_mass, {FRAC_BITS{1'b0}}}) + NUM_W'(mag_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= in_meta;
         rem_ff[0]  <= '0;
         d_ff[0]    <= mag_in;
         nq_ff[0]   <= num_in;
      end
   end

   // one restoring step per stage: dividend bits shift out, quotient bits in
   for (genvar i = 0; i < NUM_W; i++) begin : g_step
      logic [MAG_W:0] trial;
      logic           take;

      assign trial = {rem_ff[i], nq_ff[i][NUM_W-1]};
      assign take  = trial >= {1'b0, d_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff[i+1] <= meta_ff[i];
            d_ff[i+1]    <= d_ff[i];
            rem_ff[i+1]  <= take ? MAG_W'(trial - {1'b0, d_ff[i]}) : MAG_W'(trial);
            nq_ff[i+1]   <= {nq_ff[i][NUM_W-2:0], take};
         end
      end
   end

   // apply sign of the area and saturate
   always_comb begin
      qx_in = QX_W'(nq_ff[NUM_W]);
      if (!meta_ff[NUM_W].area[OUT_W-1]) begin
         dens_in = (qx_in > QX_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(qx_in);
      end else begin
         dens_in = (qx_in > QX_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(QX_W'(0) - qx_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_o_ff <= meta_ff[NUM_W];
         dens_ff   <= dens_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_meta  = meta_o_ff;
   assign out_dens  = dens_ff;

endmodule

// ----- src/qcap_press.sv -----
module qcap_press #(
   parameter int FRAC_BITS = qcap_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  qcap_pkg::cell_meta_type               in_meta,
   input  logic signed [qcap_pkg::OUT_W-1:0]     in_dens,
   output logic                                  out_valid,
   output qcap_pkg::rsp_beat_type                out_beat
);
   import qcap_pkg::*;

   localparam int GL_W  = 26;              // low part of ge, unsigned
   localparam int GH_W  = GE_W - GL_W;     // high part of ge, signed
   localparam int DL_W  = OUT_W / 2;       // low part of density, unsigned
   localparam int DH_W  = OUT_W - DL_W;    // high part of density, signed
   localparam int ACC_W = GE_W + OUT_W + 1;

   logic                    v_ff    [4];
   cell_meta_type           meta_ff [4];
   logic signed [OUT_W-1:0] dens_ff [4];

   // stage 1: four partial products
   logic        [GL_W+DL_W-1:0]   pll_ff;
   logic signed [GL_W+DH_W:0]     plh_ff;
   logic signed [GH_W+DL_W:0]     phl_ff;
   logic signed [GH_W+DH_W-1:0]   phh_ff;
   // stage 2: two half sums
   logic signed [ACC_W-1:0]       sl_ff;
   logic signed [ACC_W-1:0]       sh_ff;
   // stage 3: full product, rounded
   logic signed [ACC_W-1:0]       tot_ff;
   // stage 4: result beat
   rsp_beat_type                  beat_ff;

   logic signed [ACC_W-1:0]       shr_in;
   logic [ACC_W-OUT_W:0]          hi_in;
   logic signed [OUT_W-1:0]       press_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < 4; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= in_meta;
         dens_ff[0] <= in_dens;
         for (int s = 1; s < 4; s++) begin
            meta_ff[s] <= meta_ff[s-1];
            dens_ff[s] <= dens_ff[s-1];
         end
      end
   end

   // product split into partial products, then summed over two stages
   always_ff @(posedge clock) begin
      if (en) begin
         pll_ff <= in_meta.ge[GL_W-1:0] * in_dens[DL_W-1:0];
         plh_ff <= $signed({1'b0, in_meta.ge[GL_W-1:0]}) * $signed(in_dens[OUT_W-1:DL_W]);
         phl_ff <= $signed(in_meta.ge[GE_W-1:GL_W]) * $signed({1'b0, in_dens[DL_W-1:0]});
         phh_ff <= $signed(in_meta.ge[GE_W-1:GL_W]) * $signed(in_dens[OUT_W-1:DL_W]);
         sl_ff  <= $signed(ACC_W'(pll_ff)) + (ACC_W'(plh_ff) <<< DL_W);
         sh_ff  <= ACC_W'(phl_ff) + (ACC_W'(phh_ff) <<< DL_W);
         tot_ff <= sl_ff + (sh_ff <<< GL_W)
                 + (ACC_W'(1) <<< (FRAC_BITS + GAMMA_FRAC - 1));
      end
   end

   // scale back and saturate
   always_comb begin
      shr_in = tot_ff >>> (FRAC_BITS + GAMMA_FRAC);
      hi_in  = shr_in[ACC_W-1:OUT_W-1];
      if ((&hi_in) || !(|hi_in)) begin
         press_in = shr_in[OUT_W-1:0];
      end else if (shr_in[ACC_W-1]) begin
         press_in = OUT_MIN;
      end else begin
         press_in = OUT_MAX;
      end
   end

   // flagged cells give zeros
   always_ff @(posedge clock) begin
      if (en) begin
         beat_ff.bad_cell      <= meta_ff[2].bad;
         beat_ff.cell_area     <= meta_ff[2].bad ? '0 : meta_ff[2].area;
         beat_ff.cell_density  <= meta_ff[2].bad ? '0 : dens_ff[2];
         beat_ff.cell_pressure <= meta_ff[2].bad ? '0 : press_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_beat  = beat_ff;

endmodule
